// ----- sv/frd_pkg.sv -----
// Shared constants, types and control structs for the frequency ranking block.
`default_nettype none
package frd_pkg;

    localparam int VALUE_RANGE = 64;
    localparam int VALUE_W     = 6;
    localparam int CNT_W       = 8;
    localparam int POS_W       = 7;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    localparam logic [CNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DRAIN,
        ST_SCAN,
        ST_EMIT,
        ST_CLEAR
    } frd_state_t;

    typedef struct packed {
        logic load;
        logic round_start;
        logic scan_en;
        logic emit_done;
        logic clear;
    } frd_cmd_t;

    typedef struct packed {
        logic load_busy;
        logic scan_done;
        logic last_round;
        logic empty;
    } frd_status_t;

endpackage
`default_nettype wire

// ----- sv/frd_datapath.sv -----
// Datapath: histogram and first-seen memories, load pipeline and rank scan.
`default_nettype none
module frd_datapath (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  wire frd_pkg::frd_cmd_t             cmd,
    input  wire logic [frd_pkg::VALUE_W-1:0]   in_value,
    output frd_pkg::frd_status_t               status,
    output logic [frd_pkg::VALUE_W-1:0]        best_value,
    output logic [frd_pkg::CNT_W-1:0]          best_count
);

    logic [frd_pkg::CNT_W-1:0]       hist_mem [frd_pkg::VALUE_RANGE];
    logic [frd_pkg::VALUE_W-1:0]     order_mem [frd_pkg::VALUE_RANGE];

    logic [frd_pkg::VALUE_RANGE-1:0] hist_valid_reg;
    logic [frd_pkg::VALUE_RANGE-1:0] emitted_reg;
    logic [frd_pkg::CNT_W-1:0]       hist_rdata_reg;
    logic [frd_pkg::VALUE_W-1:0]     order_rdata_reg;

    // load pipeline
    logic                            s1_valid_reg;
    logic [frd_pkg::VALUE_W-1:0]     s1_value_reg;
    logic                            fwd_valid_reg;
    logic [frd_pkg::VALUE_W-1:0]     fwd_addr_reg;
    logic [frd_pkg::CNT_W-1:0]       fwd_data_reg;
    logic [frd_pkg::POS_W-1:0]       distinct_reg;

    // scan pipeline
    logic [frd_pkg::POS_W-1:0]       p_reg;
    logic                            a_valid_reg;
    logic [frd_pkg::VALUE_W-1:0]     a_pos_reg;
    logic                            b_valid_reg;
    logic [frd_pkg::VALUE_W-1:0]     b_pos_reg;
    logic [frd_pkg::VALUE_W-1:0]     b_value_reg;
    logic                            found_reg;
    logic [frd_pkg::VALUE_W-1:0]     best_pos_reg;
    logic [frd_pkg::VALUE_W-1:0]     best_value_reg;
    logic [frd_pkg::CNT_W-1:0]       best_count_reg;
    logic [frd_pkg::POS_W-1:0]       k_reg;

    logic [frd_pkg::CNT_W-1:0]       cur_count;
    logic [frd_pkg::CNT_W-1:0]       new_count;
    logic                            issue;
    logic                            cand;
    logic [frd_pkg::VALUE_W-1:0]     hist_raddr;

    assign issue = cmd.scan_en && (p_reg < distinct_reg);
    assign hist_raddr = cmd.load ? in_value : order_rdata_reg;

    always_comb begin
        if (!hist_valid_reg[s1_value_reg]) begin
            cur_count = '0;
        end else if (fwd_valid_reg && (fwd_addr_reg == s1_value_reg)) begin
            cur_count = fwd_data_reg;
        end else begin
            cur_count = hist_rdata_reg;
        end
        new_count = (cur_count < frd_pkg::COUNT_MAX) ? cur_count + 1'b1 : cur_count;
    end

    assign cand = b_valid_reg && !emitted_reg[b_pos_reg];

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.load || a_valid_reg) begin
            hist_rdata_reg <= hist_mem[hist_raddr];
        end
        if (s1_valid_reg) begin
            hist_mem[s1_value_reg] <= new_count;
        end
        if (issue) begin
            order_rdata_reg <= order_mem[p_reg[frd_pkg::VALUE_W-1:0]];
        end
        if (s1_valid_reg && (cur_count == '0)) begin
            order_mem[distinct_reg[frd_pkg::VALUE_W-1:0]] <= s1_value_reg;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        s1_value_reg <= in_value;
        fwd_addr_reg <= s1_value_reg;
        fwd_data_reg <= new_count;
        a_pos_reg    <= p_reg[frd_pkg::VALUE_W-1:0];
        b_pos_reg    <= a_pos_reg;
        b_value_reg  <= order_rdata_reg;
        if (cand && (!found_reg || (hist_rdata_reg > best_count_reg))) begin
            best_pos_reg   <= b_pos_reg;
            best_value_reg <= b_value_reg;
            best_count_reg <= hist_rdata_reg;
        end
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            hist_valid_reg <= '0;
            emitted_reg    <= '0;
            distinct_reg   <= '0;
            p_reg          <= '0;
            a_valid_reg    <= 1'b0;
            b_valid_reg    <= 1'b0;
            found_reg      <= 1'b0;
            k_reg          <= '0;
        end else begin
            s1_valid_reg  <= cmd.load;
            fwd_valid_reg <= s1_valid_reg;
            a_valid_reg   <= issue;
            b_valid_reg   <= a_valid_reg;
            if (s1_valid_reg) begin
                hist_valid_reg[s1_value_reg] <= 1'b1;
                if (cur_count == '0) begin
                    distinct_reg <= distinct_reg + 1'b1;
                end
            end
            if (issue) begin
                p_reg <= p_reg + 1'b1;
            end
            if (cand && (!found_reg || (hist_rdata_reg > best_count_reg))) begin
                found_reg <= 1'b1;
            end
            if (cmd.round_start) begin
                p_reg     <= '0;
                found_reg <= 1'b0;
            end
            if (cmd.emit_done) begin
                emitted_reg[best_pos_reg] <= 1'b1;
                k_reg <= k_reg + 1'b1;
            end
            if (cmd.clear) begin
                hist_valid_reg <= '0;
                emitted_reg    <= '0;
                distinct_reg   <= '0;
                k_reg          <= '0;
            end
        end
    end

    always_comb begin
        status.load_busy  = s1_valid_reg;
        status.scan_done  = (p_reg == distinct_reg) && !a_valid_reg && !b_valid_reg;
        status.last_round = (k_reg == distinct_reg - 1'b1);
        status.empty      = (distinct_reg == '0);
    end

    assign best_value = best_value_reg;
    assign best_count = best_count_reg;

endmodule
`default_nettype wire

// ----- sv/frd_ctrl.sv -----
// Controller: sequences intake, drain, rank rounds, beat output and clear.
`default_nettype none
module frd_ctrl (
    input  wire                        aclk,
    input  wire                        aresetn,
    input  wire                        s_tvalid,
    input  wire                        s_tlast,
    input  wire                        m_tready,
    input  wire frd_pkg::frd_status_t  status,
    output logic                       s_tready,
    output logic                       m_tvalid,
    output frd_pkg::frd_cmd_t          cmd
);

    frd_pkg::frd_state_t state_reg;
    frd_pkg::frd_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= frd_pkg::ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            frd_pkg::ST_LOAD: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = frd_pkg::ST_DRAIN;
                end
            end
            frd_pkg::ST_DRAIN: begin
                if (!status.load_busy) begin
                    if (status.empty) begin
                        state_next = frd_pkg::ST_CLEAR;
                    end else begin
                        cmd.round_start = 1'b1;
                        state_next      = frd_pkg::ST_SCAN;
                    end
                end
            end
            frd_pkg::ST_SCAN: begin
                cmd.scan_en = 1'b1;
                if (status.scan_done) begin
                    state_next = frd_pkg::ST_EMIT;
                end
            end
            frd_pkg::ST_EMIT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    cmd.emit_done = 1'b1;
                    if (status.last_round) begin
                        state_next = frd_pkg::ST_CLEAR;
                    end else begin
                        cmd.round_start = 1'b1;
                        state_next      = frd_pkg::ST_SCAN;
                    end
                end
            end
            frd_pkg::ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = frd_pkg::ST_LOAD;
            end
            default: begin
                state_next = frd_pkg::ST_LOAD;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- sv/frequency_rank_distinct_core.sv -----
// Top level of the frequency ranking block: controller plus datapath.
//
//  channel | dir | tdata (low bit up)                      | tlast
//  s_      | in  | value[5:0], zero pad[7:6]               | last element of set
//  m_      | out | ranked_value[5:0], occurrences[13:6],   | last ranked value
//          |     | zero pad[15:14]                         |
//
// Intake takes one beat per cycle; the histogram read-modify-write is a
// two-stage pipeline with write forwarding.
// After the last beat the load pipeline drains, then for n distinct values
// n rounds run, each a scan through the order and histogram memories
// followed by one output beat; then a clear step.
// Reset is immediate: per-value valid bits, no clearing pass.
// s_tready is low from the last beat until the set is fully emitted and cleared;
// a stalled m_ beat holds the scan.
`default_nettype none
module frequency_rank_distinct_core (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [frd_pkg::S_TDATA_W-1:0]       s_tdata,   // value[5:0]
    input  wire                                 s_tlast,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [frd_pkg::M_TDATA_W-1:0]       m_tdata,   // ranked_value[5:0], occurrences[13:6]
    output logic                                m_tlast
);

    frd_pkg::frd_cmd_t                cmd;
    frd_pkg::frd_status_t             status;
    logic [frd_pkg::VALUE_W-1:0]      best_value;
    logic [frd_pkg::CNT_W-1:0]        best_count;

    frd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    frd_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_value   (s_tdata[frd_pkg::VALUE_W-1:0]),
        .status     (status),
        .best_value (best_value),
        .best_count (best_count)
    );

    assign m_tdata = {{(frd_pkg::M_TDATA_W - frd_pkg::VALUE_W - frd_pkg::CNT_W){1'b0}},
                      best_count, best_value};
    assign m_tlast = status.last_round;

endmodule
`default_nettype wire

// ----- sv/frd_checker.sv -----
// Port-level checks for the frequency ranking block, bound to the top level.
`default_nettype none
module frd_checker (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               s_tlast,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [frd_pkg::M_TDATA_W-1:0]      m_tdata,
    input wire                               m_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // intake and ranking never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("intake open while ranking output");

    // every emitted value was seen at least once
    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[13:6] != 8'd0)
        else $error("zero occurrence count emitted");

    // intake closes after the last beat of a set
    a_close_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready && !m_tvalid)
        else $error("intake not closed after last beat");

    // final ranked beat ends the output run
    a_end_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid)
        else $error("output continued after final ranked beat");

endmodule

bind frequency_rank_distinct_core frd_checker u_frd_checker (.*);
`default_nettype wire

// ----- verif/frequency_rank_distinct_core_test.sv -----
// Testbench for frequency_rank_distinct_core: value sets and ranked-output scoreboard.
module frequency_rank_distinct_core_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_BEATS = 180;

    typedef logic [frd_pkg::VALUE_W-1:0] value_t;

    typedef struct packed {
        logic [frd_pkg::VALUE_W-1:0] value;
        logic [frd_pkg::CNT_W-1:0]   count;
        logic                        final_flag;
    } ranked_t;

    logic                          aclk;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [frd_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tlast = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [frd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    // predictor state for the set being loaded
    int                   tally [frd_pkg::VALUE_RANGE];
    value_t               arrival [$];
    ranked_t              pending_ranks [$];

    bit steady = 1'b0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int mismatches = 0;
    int beats_in = 0;
    int sets_sent = 0;
    int ranks_seen = 0;
    int cycle_count = 0;

    frequency_rank_distinct_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d ranks still pending", $time, pending_ranks.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(0, 99) >= 8);
        end
    end

    always @(posedge aclk) begin
        ranked_t got;
        ranked_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.value      = m_tdata[frd_pkg::VALUE_W-1:0];
            got.count      = m_tdata[frd_pkg::VALUE_W+frd_pkg::CNT_W-1:frd_pkg::VALUE_W];
            got.final_flag = m_tlast;
            ranks_seen++;
            if (pending_ranks.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected beat value=%0d count=%0d last=%0b",
                         $time, got.value, got.count, got.final_flag);
            end else begin
                want = pending_ranks.pop_front();
                if (got.value !== want.value) begin
                    mismatches++;
                    $display("%0t: ranked_value expected %0d actual %0d",
                             $time, want.value, got.value);
                end
                if (got.count !== want.count) begin
                    mismatches++;
                    $display("%0t: occurrences of %0d expected %0d actual %0d",
                             $time, want.value, want.count, got.count);
                end
                if (got.final_flag !== want.final_flag) begin
                    mismatches++;
                    $display("%0t: tlast on %0d expected %0b actual %0b",
                             $time, want.value, want.final_flag, got.final_flag);
                end
            end
        end
    end

    // stable rank: count descending, ties by first appearance
    function automatic void rank_set();
        bit      taken [frd_pkg::VALUE_RANGE];
        int      n;
        int      best;
        ranked_t r;
        n = arrival.size();
        foreach (taken[i]) taken[i] = 1'b0;
        for (int k = 0; k < n; k++) begin
            best = -1;
            for (int p = 0; p < n; p++) begin
                if (!taken[p] && (best < 0 || tally[arrival[p]] > tally[arrival[best]]))
                    best = p;
            end
            taken[best] = 1'b1;
            r.value      = arrival[best];
            r.count      = tally[arrival[best]][frd_pkg::CNT_W-1:0];
            r.final_flag = (k == n - 1);
            pending_ranks.push_back(r);
        end
        foreach (tally[i]) tally[i] = 0;
        arrival.delete();
    endfunction

    function automatic void count_value(value_t v, logic lst);
        if (tally[v] == 0)
            arrival.push_back(v);
        if (tally[v] < int'(frd_pkg::COUNT_MAX))
            tally[v]++;
        if (lst) begin
            rank_set();
            sets_sent++;
        end
    endfunction

    task automatic send_beat(input value_t v, input logic lst);
        if (!steady && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(frd_pkg::S_TDATA_W-frd_pkg::VALUE_W){1'b0}}, v};
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        beats_in++;
        count_value(v, lst);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_ranks.size() != 0) @(posedge aclk);
    endtask

    task automatic send_random_set(input int size, input int pool_size);
        value_t pool [8];
        foreach (pool[i]) pool[i] = value_t'($urandom_range(0, frd_pkg::VALUE_RANGE - 1));
        for (int i = 0; i < size; i++) begin
            if (pool_size == 0)
                send_beat(value_t'($urandom_range(0, frd_pkg::VALUE_RANGE - 1)),
                          i == size - 1);
            else
                send_beat(pool[$urandom_range(0, pool_size - 1)], i == size - 1);
        end
    endtask

    task automatic send_permutation();
        value_t perm [frd_pkg::VALUE_RANGE];
        value_t tmp;
        int     j;
        foreach (perm[i]) perm[i] = value_t'(i);
        for (int i = frd_pkg::VALUE_RANGE - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        foreach (perm[i]) send_beat(perm[i], i == frd_pkg::VALUE_RANGE - 1);
    endtask

    task automatic test_single_values();
        send_beat(6'd0, 1'b1);
        send_beat(6'd63, 1'b1);
    endtask

    task automatic test_extremes_and_ties();
        // equal counts keep arrival order
        send_beat(6'd0, 1'b0);
        send_beat(6'd63, 1'b0);
        send_beat(6'd0, 1'b0);
        send_beat(6'd63, 1'b0);
        send_beat(6'd63, 1'b0);
        send_beat(6'd0, 1'b1);
        send_beat(6'd5, 1'b0);
        send_beat(6'd3, 1'b0);
        send_beat(6'd5, 1'b0);
        send_beat(6'd3, 1'b1);
        // higher count beats earlier arrival
        send_beat(6'd7, 1'b0);
        send_beat(6'd7, 1'b0);
        send_beat(6'd1, 1'b0);
        send_beat(6'd1, 1'b0);
        send_beat(6'd1, 1'b1);
    endtask

    task automatic test_saturation();
        // 5 clips at the count ceiling and outranks 9, which came first
        send_beat(6'd9, 1'b0);
        repeat (256) send_beat(6'd5, 1'b0);
        send_beat(6'd9, 1'b0);
        send_beat(6'd33, 1'b1);
    endtask

    task automatic test_output_holdoff();
        hold_req++;
        for (int s = 0; s < 3; s++)
            send_random_set($urandom_range(4, 10), $urandom_range(1, 5));
        wait_drained();
    endtask

    task automatic test_pause_until_drained();
        send_random_set($urandom_range(5, 12), 4);
        wait_drained();
        send_random_set($urandom_range(5, 12), 0);
    endtask

    task automatic test_random_sets();
        int start_beats;
        int perms;
        int style;
        int set_idx;
        start_beats = beats_in;
        perms = 0;
        set_idx = 0;
        while (beats_in - start_beats < RANDOM_BEATS) begin
            steady = (set_idx >= 3 && set_idx < 9);
            style = $urandom_range(0, 9);
            if ((set_idx == 0 || style == 9) && perms < 2) begin
                send_permutation();
                perms++;
            end else if (style >= 6) begin
                send_random_set($urandom_range(1, 40), 0);
            end else begin
                send_random_set($urandom_range(1, 24), $urandom_range(1, 8));
            end
            set_idx++;
        end
        steady = 1'b0;
    endtask

    initial begin
        foreach (tally[i]) tally[i] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_single_values();
        test_extremes_and_ties();
        test_saturation();
        test_output_holdoff();
        test_pause_until_drained();
        test_random_sets();
        wait_drained();
        repeat (100) @(posedge aclk);
        $display("Ran %0d sets, %0d value beats in, %0d ranked beats out", sets_sent,
                 beats_in, ranks_seen);
        $display("incl. count clipping, tie order, full 64-value sets, output hold-off");
        if (mismatches == 0 && pending_ranks.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0t: %0d mismatches, %0d ranks never arrived", $time, mismatches,
                     pending_ranks.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
